// File: src/perel_pkg.sv
// Shared types and codes of the relocation stream parser.
`timescale 1ns / 1ps

package perel_pkg;

   // Walk position inside the directory: four header words, then entries.
   typedef enum logic [2:0] {
      PH_PAGE_LO  = 3'd0,
      PH_PAGE_HI  = 3'd1,
      PH_SIZE_LO  = 3'd2,
      PH_SIZE_HI  = 3'd3,
      PH_ENTRY    = 3'd4
   } phase_type;

   // Result status, carried on the result tuser.
   localparam logic [1:0] ST_PATCH    = 2'd0;
   localparam logic [1:0] ST_DONE     = 2'd1;
   localparam logic [1:0] ST_NO_FIXUP = 2'd2;
   localparam logic [1:0] ST_BAD_TYPE = 2'd3;

   // Patch kinds.
   localparam logic [2:0] KIND_HIGH16  = 3'd0;
   localparam logic [2:0] KIND_LOW16   = 3'd1;
   localparam logic [2:0] KIND_ADD32   = 3'd2;
   localparam logic [2:0] KIND_ADD64   = 3'd3;
   localparam logic [2:0] KIND_HIGHADJ = 3'd4;

   // Relocation entry types.
   localparam logic [3:0] RT_ABSOLUTE = 4'd0;
   localparam logic [3:0] RT_HIGH     = 4'd1;
   localparam logic [3:0] RT_LOW      = 4'd2;
   localparam logic [3:0] RT_HIGHLOW  = 4'd3;
   localparam logic [3:0] RT_HIGHADJ  = 4'd4;
   localparam logic [3:0] RT_DIR64    = 4'd10;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DELTA      = 2'd0;
   localparam logic [1:0] CSR_IMAGE_BASE = 2'd1;
   localparam logic [1:0] CSR_DIR_BYTES  = 2'd2;

   localparam int unsigned RSP_DATA_W = 88;

endpackage

// File: src/pe_relocation_stream_parser.sv
// Top level of the relocation stream parser: word decode, walk state and result register.
`timescale 1ns / 1ps

// The block walks a base-relocation directory that arrives as 16-bit words,
// one word per beat on the req_ channel. Each block of the directory opens
// with four header words (page address low and high, block size low and high)
// and is followed by entry words of a 4-bit type and a 12-bit offset.
// For every fixup one beat leaves on the rsp_ channel with the patch address,
// the kind and the addend; absolute entries and header words give no beat.
// A HIGHADJ entry is reported together with the word that follows it.
// With a nonzero delta an unknown type raises a sticky error, repeated for
// every later word, and once the configured directory length is consumed
// each word is answered with a finished status.
// The csr_ port loads delta, image base and directory length; it is to be
// written only while the block is idle; the block itself does not enforce this.
// Each word is decoded in the cycle it is accepted and its result sits in the
// output register from the next cycle, and one word can be accepted in every
// cycle while the single output register is empty or its beat is leaving.
// When the receiver stalls, the output register holds its beat and req_tready
// stays high only if that beat leaves in the same cycle.
// Synchronous reset clears the configuration, the walk state and the
// output register; the block is ready as soon as reset is released.

module pe_relocation_stream_parser (
   input  logic        clock,
   input  logic        reset,
   // Directory words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] word_in
   // Patch commands and status.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] patch_kind, [34:3] patch_address, [66:35] addend,
   // [82:67] low_part, [86:83] bad_type, [87] zero fill
   output logic [perel_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration writes.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Configuration registers.
   logic [31:0] delta_ff;
   logic [31:0] image_base_ff;
   logic [31:0] dir_bytes_ff;

   // Walk state.
   perel_pkg::phase_type phase_ff, phase_in;
   logic [15:0] hdr_low_ff, hdr_low_in;
   logic [31:0] page_addr_ff, page_addr_in;
   logic [31:0] words_left_ff, words_left_in;
   logic [31:0] bytes_used_ff, bytes_used_in;
   logic        hadj_ff, hadj_in;
   logic [31:0] hadj_addr_ff, hadj_addr_in;
   logic        error_ff, error_in;
   logic [3:0]  error_type_ff, error_type_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [31:0] rsp_addend_ff, rsp_addend_in;
   logic [15:0] rsp_low_ff, rsp_low_in;
   logic [3:0]  rsp_bad_ff, rsp_bad_in;

   logic        accept;
   logic        emit;
   logic        finished;
   logic [3:0]  entry_type;
   logic [31:0] entry_addr;
   logic [31:0] block_size;
   logic [31:0] slot_left;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign entry_type = req_tdata[15:12];
   assign entry_addr = image_base_ff + page_addr_ff + {20'd0, req_tdata[11:0]};
   assign block_size = {req_tdata, hdr_low_ff};
   // Entry slot count once the current word has taken its slot.
   assign slot_left  = (words_left_ff != 32'd0) ? words_left_ff - 32'd1 : words_left_ff;
   assign finished   = (phase_ff == perel_pkg::PH_PAGE_LO) && !hadj_ff
                       && (bytes_used_ff >= dir_bytes_ff);

   always_comb begin
      phase_in      = phase_ff;
      hdr_low_in    = hdr_low_ff;
      page_addr_in  = page_addr_ff;
      words_left_in = words_left_ff;
      bytes_used_in = bytes_used_ff;
      hadj_in       = hadj_ff;
      hadj_addr_in  = hadj_addr_ff;
      error_in      = error_ff;
      error_type_in = error_type_ff;
      emit          = 1'b0;
      rsp_status_in = perel_pkg::ST_PATCH;
      rsp_kind_in   = 3'd0;
      rsp_addr_in   = 32'd0;
      rsp_addend_in = 32'd0;
      rsp_low_in    = 16'd0;
      rsp_bad_in    = 4'd0;

      if (error_ff) begin
         emit          = 1'b1;
         rsp_status_in = perel_pkg::ST_BAD_TYPE;
         rsp_bad_in    = error_type_ff;
      end else if (finished) begin
         emit          = 1'b1;
         rsp_status_in = (delta_ff != 32'd0) ? perel_pkg::ST_DONE : perel_pkg::ST_NO_FIXUP;
      end else begin
         // The byte counter saturates rather than wrapping.
         bytes_used_in = (bytes_used_ff >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF
                                                          : bytes_used_ff + 32'd2;
         if (hadj_ff) begin
            // This word is the low part of the pending HIGHADJ entry.
            hadj_in       = 1'b0;
            words_left_in = slot_left;
            if (slot_left == 32'd0) begin
               phase_in = perel_pkg::PH_PAGE_LO;
            end
            emit          = 1'b1;
            rsp_kind_in   = perel_pkg::KIND_HIGHADJ;
            rsp_addr_in   = hadj_addr_ff;
            rsp_addend_in = {16'd0, delta_ff[31:16]};
            rsp_low_in    = req_tdata;
         end else begin
            unique case (phase_ff)
               perel_pkg::PH_PAGE_LO: begin
                  hdr_low_in = req_tdata;
                  phase_in   = perel_pkg::PH_PAGE_HI;
               end
               perel_pkg::PH_PAGE_HI: begin
                  page_addr_in = {req_tdata, hdr_low_ff};
                  phase_in     = perel_pkg::PH_SIZE_LO;
               end
               perel_pkg::PH_SIZE_LO: begin
                  hdr_low_in = req_tdata;
                  phase_in   = perel_pkg::PH_SIZE_HI;
               end
               perel_pkg::PH_SIZE_HI: begin
                  // The size includes the 8-byte header; an odd tail takes a slot.
                  if (block_size > 32'd8) begin
                     words_left_in = (block_size - 32'd7) >> 1;
                     phase_in      = perel_pkg::PH_ENTRY;
                  end else begin
                     words_left_in = 32'd0;
                     phase_in      = perel_pkg::PH_PAGE_LO;
                  end
               end
               perel_pkg::PH_ENTRY: begin
                  words_left_in = slot_left;
                  if (slot_left == 32'd0) begin
                     phase_in = perel_pkg::PH_PAGE_LO;
                  end
                  // With a zero delta the entries are walked but nothing is patched.
                  if (delta_ff != 32'd0) begin
                     unique case (entry_type)
                        perel_pkg::RT_ABSOLUTE: begin
                        end
                        perel_pkg::RT_HIGH: begin
                           emit          = 1'b1;
                           rsp_kind_in   = perel_pkg::KIND_HIGH16;
                           rsp_addr_in   = entry_addr;
                           rsp_addend_in = {16'd0, delta_ff[31:16]};
                        end
                        perel_pkg::RT_LOW: begin
                           emit          = 1'b1;
                           rsp_kind_in   = perel_pkg::KIND_LOW16;
                           rsp_addr_in   = entry_addr;
                           rsp_addend_in = {16'd0, delta_ff[15:0]};
                        end
                        perel_pkg::RT_HIGHLOW: begin
                           emit          = 1'b1;
                           rsp_kind_in   = perel_pkg::KIND_ADD32;
                           rsp_addr_in   = entry_addr;
                           rsp_addend_in = delta_ff;
                        end
                        perel_pkg::RT_DIR64: begin
                           emit          = 1'b1;
                           rsp_kind_in   = perel_pkg::KIND_ADD64;
                           rsp_addr_in   = entry_addr;
                           rsp_addend_in = delta_ff;
                        end
                        perel_pkg::RT_HIGHADJ: begin
                           hadj_in      = 1'b1;
                           hadj_addr_in = entry_addr;
                        end
                        default: begin
                           error_in      = 1'b1;
                           error_type_in = entry_type;
                           emit          = 1'b1;
                           rsp_status_in = perel_pkg::ST_BAD_TYPE;
                           rsp_bad_in    = entry_type;
                        end
                     endcase
                  end
               end
               default: begin
                  phase_in = perel_pkg::PH_PAGE_LO;
               end
            endcase
         end
      end

      if (accept) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff      <= 32'd0;
         image_base_ff <= 32'd0;
         dir_bytes_ff  <= 32'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            perel_pkg::CSR_DELTA:      delta_ff      <= csr_wdata;
            perel_pkg::CSR_IMAGE_BASE: image_base_ff <= csr_wdata;
            perel_pkg::CSR_DIR_BYTES:  dir_bytes_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= perel_pkg::PH_PAGE_LO;
         hdr_low_ff    <= 16'd0;
         page_addr_ff  <= 32'd0;
         words_left_ff <= 32'd0;
         bytes_used_ff <= 32'd0;
         hadj_ff       <= 1'b0;
         hadj_addr_ff  <= 32'd0;
         error_ff      <= 1'b0;
         error_type_ff <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            hdr_low_ff    <= hdr_low_in;
            page_addr_ff  <= page_addr_in;
            words_left_ff <= words_left_in;
            bytes_used_ff <= bytes_used_in;
            hadj_ff       <= hadj_in;
            hadj_addr_ff  <= hadj_addr_in;
            error_ff      <= error_in;
            error_type_ff <= error_type_in;
         end
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_addend_ff <= rsp_addend_in;
         rsp_low_ff    <= rsp_low_in;
         rsp_bad_ff    <= rsp_bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_bad_ff, rsp_low_ff, rsp_addend_ff, rsp_addr_ff, rsp_kind_ff};

   // The error, once raised, stays until reset.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("sticky error cleared");

   // A HIGHADJ entry and a type error are never outstanding together.
   a_hadj_no_error: assert property (@(posedge clock) disable iff (reset)
      !(hadj_ff && error_ff))
      else $error("highadj pending while in error");

   // Entry phase always has at least one slot left in the block.
   a_entry_has_slot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == perel_pkg::PH_ENTRY) |-> (words_left_ff != 32'd0))
      else $error("entry phase with no slots left");

   // A word taken in error state is answered with an error beat.
   a_error_reply: assert property (@(posedge clock) disable iff (reset)
      (accept && error_ff) |=> (rsp_tvalid && rsp_tuser == perel_pkg::ST_BAD_TYPE))
      else $error("error state gave no error beat");

endmodule

// File: dv/perel_patch_checker.sv
// Checker for the relocation stream parser: walks the directory alongside the block and compares patch beats.
`timescale 1ns / 1ps

module perel_patch_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [15:0]                      req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [perel_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                       rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_index,
   input  logic [31:0]                      csr_wdata,
   output int                               mismatches,
   output int                               outstanding
);

   localparam int FILL_BIT = 87;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  kind;
      logic [31:0] address;
      logic [31:0] addend;
      logic [15:0] low_part;
      logic [3:0]  bad_type;
   } patch_type;

   patch_type pending_patches[$];

   logic [31:0] delta_reg;
   logic [31:0] base_reg;
   logic [31:0] dir_bytes_reg;

   perel_pkg::phase_type walk_phase;
   logic [15:0] half_word;
   logic [31:0] page_addr;
   logic [31:0] slots_left;
   logic [31:0] bytes_walked;
   logic        adj_pending;
   logic [31:0] adj_address;
   logic        err_sticky;
   logic [3:0]  err_code;

   function automatic void clear_walk();
      walk_phase   = perel_pkg::PH_PAGE_LO;
      half_word    = '0;
      page_addr    = '0;
      slots_left   = '0;
      bytes_walked = '0;
      adj_pending  = 1'b0;
      adj_address  = '0;
      err_sticky   = 1'b0;
      err_code     = '0;
   endfunction

   function automatic void use_slot();
      if (slots_left != 0) begin
         slots_left = slots_left - 1;
      end
      if (slots_left == 0) begin
         walk_phase = perel_pkg::PH_PAGE_LO;
      end
   endfunction

   // Advances the walk by one directory word; returns 1 when the word yields a beat.
   function automatic bit walk_word(input logic [15:0] w, output patch_type res);
      logic [3:0]  rtype;
      logic [31:0] addr;
      logic [31:0] blk_size;
      bit          made;
      made = 1'b0;
      res  = '0;
      if (err_sticky) begin
         res.status   = perel_pkg::ST_BAD_TYPE;
         res.bad_type = err_code;
         return 1'b1;
      end
      if (walk_phase == perel_pkg::PH_PAGE_LO && !adj_pending
          && bytes_walked >= dir_bytes_reg) begin
         res.status = (delta_reg != 0) ? perel_pkg::ST_DONE : perel_pkg::ST_NO_FIXUP;
         return 1'b1;
      end
      bytes_walked = (bytes_walked >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : bytes_walked + 32'd2;
      if (adj_pending) begin
         adj_pending  = 1'b0;
         use_slot();
         res.status   = perel_pkg::ST_PATCH;
         res.kind     = perel_pkg::KIND_HIGHADJ;
         res.address  = adj_address;
         res.addend   = {16'h0000, delta_reg[31:16]};
         res.low_part = w;
         return 1'b1;
      end
      case (walk_phase)
         perel_pkg::PH_PAGE_LO: begin
            half_word  = w;
            walk_phase = perel_pkg::PH_PAGE_HI;
         end
         perel_pkg::PH_PAGE_HI: begin
            page_addr  = {w, half_word};
            walk_phase = perel_pkg::PH_SIZE_LO;
         end
         perel_pkg::PH_SIZE_LO: begin
            half_word  = w;
            walk_phase = perel_pkg::PH_SIZE_HI;
         end
         perel_pkg::PH_SIZE_HI: begin
            blk_size   = {w, half_word};
            slots_left = (blk_size > 8) ? (blk_size - 32'd7) >> 1 : 32'd0;
            walk_phase = (slots_left != 0) ? perel_pkg::PH_ENTRY : perel_pkg::PH_PAGE_LO;
         end
         perel_pkg::PH_ENTRY: begin
            rtype = w[15:12];
            addr  = base_reg + page_addr + {20'h00000, w[11:0]};
            use_slot();
            if (delta_reg != 0) begin
               res.address = addr;
               case (rtype)
                  perel_pkg::RT_ABSOLUTE: ;
                  perel_pkg::RT_HIGH: begin
                     res.kind   = perel_pkg::KIND_HIGH16;
                     res.addend = {16'h0000, delta_reg[31:16]};
                     made       = 1'b1;
                  end
                  perel_pkg::RT_LOW: begin
                     res.kind   = perel_pkg::KIND_LOW16;
                     res.addend = {16'h0000, delta_reg[15:0]};
                     made       = 1'b1;
                  end
                  perel_pkg::RT_HIGHLOW: begin
                     res.kind   = perel_pkg::KIND_ADD32;
                     res.addend = delta_reg;
                     made       = 1'b1;
                  end
                  perel_pkg::RT_DIR64: begin
                     res.kind   = perel_pkg::KIND_ADD64;
                     res.addend = delta_reg;
                     made       = 1'b1;
                  end
                  perel_pkg::RT_HIGHADJ: begin
                     adj_pending = 1'b1;
                     adj_address = addr;
                  end
                  default: begin
                     err_sticky   = 1'b1;
                     err_code     = rtype;
                     res          = '0;
                     res.status   = perel_pkg::ST_BAD_TYPE;
                     res.bad_type = rtype;
                     made         = 1'b1;
                  end
               endcase
               if (!made) begin
                  res = '0;
               end
            end
         end
         default: walk_phase = perel_pkg::PH_PAGE_LO;
      endcase
      return made;
   endfunction

   task automatic note_mismatch(input string what, input patch_type want,
                                input patch_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected status %0d kind %0d addr %h addend %h low %h bad %0d",
                  $time, what, want.status, want.kind, want.address, want.addend,
                  want.low_part, want.bad_type);
         $display("      actual status %0d kind %0d addr %h addend %h low %h bad %0d fill %b",
                  seen.status, seen.kind, seen.address, seen.addend, seen.low_part,
                  seen.bad_type, rsp_tdata[FILL_BIT]);
      end
   endtask

   always @(posedge clock) begin : track
      patch_type seen;
      patch_type want;
      if (reset) begin
         clear_walk();
         delta_reg     = '0;
         base_reg      = '0;
         dir_bytes_reg = '0;
         pending_patches.delete();
      end else begin
         // Beats leaving now stem from earlier words, so they are matched first.
         if (rsp_tvalid && rsp_tready) begin
            seen.status   = rsp_tuser;
            seen.kind     = rsp_tdata[2:0];
            seen.address  = rsp_tdata[34:3];
            seen.addend   = rsp_tdata[66:35];
            seen.low_part = rsp_tdata[82:67];
            seen.bad_type = rsp_tdata[86:83];
            if (pending_patches.size() == 0) begin
               note_mismatch("unexpected result beat", '0, seen);
            end else begin
               want = pending_patches.pop_front();
               if (seen.status !== want.status || seen.kind !== want.kind ||
                   seen.address !== want.address || seen.addend !== want.addend ||
                   seen.low_part !== want.low_part || seen.bad_type !== want.bad_type ||
                   rsp_tdata[FILL_BIT] !== 1'b0) begin
                  note_mismatch("result beat differs", want, seen);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               perel_pkg::CSR_DELTA:      delta_reg     = csr_wdata;
               perel_pkg::CSR_IMAGE_BASE: base_reg      = csr_wdata;
               perel_pkg::CSR_DIR_BYTES:  dir_bytes_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (walk_word(req_tdata, want)) begin
               pending_patches.push_back(want);
            end
         end
      end
      outstanding <= pending_patches.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the relocation stream parser testbench: clock, reset, directory stimulus and verdict.
`timescale 1ns / 1ps

// The stimulus walks whole relocation directories: each phase loads the three
// registers while the block is idle, then streams a batch of blocks built here
// (header words followed by entry words), optionally followed by stray words
// that land after the end of the directory. The directory length is worked
// out from the blocks that were built, so that the block walk and the
// stimulus always agree on where the next block starts. A checker beside the
// block predicts every result beat and counts mismatches; this module only
// drives and judges.
module testbench;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted beat
   localparam int DRAIN_CYCLES   = 4;
   localparam int WORD_TARGET    = 1500;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [15:0]                      req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [perel_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             csr_wr_en  = 1'b0;
   logic [1:0]                       csr_index  = perel_pkg::CSR_DELTA;
   logic [31:0]                      csr_wdata  = '0;

   int mismatches;
   int outstanding;

   // Idle percentages of the sender and the receiver.
   int send_idle_pct = 25;
   int recv_idle_pct = 53;

   // Words of the directory batch being prepared, and the number of directory
   // bytes the block has walked so far.
   logic [15:0] dir_words[$];
   logic [31:0] dir_cursor = '0;

   int words_sent     = 0;
   int settings_used  = 0;
   int beats_taken    = 0;
   int quiet_cycles   = 0;

   always #4 clock = ~clock;

   pe_relocation_stream_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   perel_patch_checker patch_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // The receiver stalls at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: any accepted beat on either channel restarts the count. The
   // only deliberate quiet stretches are the short pauses between phases.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            beats_taken <= beats_taken + 1;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Offers one word and returns at the edge where it is accepted. The idle
   // gap comes first so that tvalid is never dropped and raised in one step.
   task automatic put_word(input logic [15:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // Waits until every predicted beat has left, then lets the block settle so
   // that a trailing header or absolute word is surely finished as well.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] delta_val, input logic [31:0] base,
                            input logic [31:0] dir_len);
      write_csr(perel_pkg::CSR_DELTA, delta_val);
      write_csr(perel_pkg::CSR_IMAGE_BASE, base);
      write_csr(perel_pkg::CSR_DIR_BYTES, dir_len);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] pick_word32();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly short blocks; empty headers and a few longer blocks now and then.
   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 12) begin
         return $urandom_range(8);
      end else if (r < 97) begin
         return $urandom_range(48, 9);
      end
      return $urandom_range(200, 49);
   endfunction

   // With a zero delta every type is harmless, so all sixteen are offered;
   // otherwise only the known types, to keep the sticky error for the end.
   function automatic logic [15:0] entry_word(input bit any_type);
      logic [3:0]  rtype;
      logic [11:0] offset;
      if (any_type) begin
         rtype = 4'($urandom_range(15));
      end else begin
         case ($urandom_range(5))
            0:       rtype = perel_pkg::RT_ABSOLUTE;
            1:       rtype = perel_pkg::RT_HIGH;
            2:       rtype = perel_pkg::RT_LOW;
            3:       rtype = perel_pkg::RT_HIGHLOW;
            4:       rtype = perel_pkg::RT_HIGHADJ;
            default: rtype = perel_pkg::RT_DIR64;
         endcase
      end
      case ($urandom_range(9))
         0:       offset = 12'h000;
         1:       offset = 12'hFFF;
         default: offset = 12'($urandom);
      endcase
      return {rtype, offset};
   endfunction

   // Appends one block to the batch and returns the bytes the block will walk.
   // When HIGHADJ is live (paired) the word after it is its low part; if the
   // entry sits in the last slot that word is taken from beyond the block.
   function automatic int build_block(input logic [31:0] page, input logic [31:0] blk_size,
                                      input bit any_type, input bit paired);
      int          slots;
      bit          low_next;
      logic [15:0] w;
      slots    = (blk_size > 8) ? int'((blk_size - 32'd7) >> 1) : 0;
      low_next = 1'b0;
      dir_words.push_back(page[15:0]);
      dir_words.push_back(page[31:16]);
      dir_words.push_back(blk_size[15:0]);
      dir_words.push_back(blk_size[31:16]);
      for (int i = 0; i < slots; i++) begin
         if (low_next) begin
            dir_words.push_back(16'($urandom));
            low_next = 1'b0;
         end else begin
            w = entry_word(any_type);
            dir_words.push_back(w);
            low_next = paired && (w[15:12] == perel_pkg::RT_HIGHADJ);
         end
      end
      if (low_next) begin
         dir_words.push_back(16'($urandom));
      end
      return 8 + 2 * slots + (low_next ? 2 : 0);
   endfunction

   // One phase: build the batch, load the registers, stream the batch and any
   // stray words, then wait for the block to drain. With past_end the length
   // ends inside the last block, which is still walked to its own end; with
   // open_end the length is the largest value and the directory never ends.
   task automatic run_phase(input logic [31:0] delta_val, input logic [31:0] base,
                            input int blocks, input int strays, input bit past_end,
                            input bit open_end);
      int          total;
      int          last_bytes;
      logic [31:0] dir_len;
      dir_words.delete();
      total      = 0;
      last_bytes = 0;
      for (int i = 0; i < blocks; i++) begin
         last_bytes = build_block(pick_word32(), pick_size(), delta_val == 0, delta_val != 0);
         total += last_bytes;
      end
      dir_len = dir_cursor + total;
      if (open_end) begin
         dir_len = 32'hFFFF_FFFF;
      end else if (past_end && last_bytes > 1) begin
         dir_len = dir_len - $urandom_range(last_bytes - 1, 1);
      end
      configure(delta_val, base, dir_len);
      foreach (dir_words[i]) begin
         put_word(dir_words[i]);
      end
      repeat (strays) put_word(16'($urandom));
      dir_cursor += total;
      settle();
   endtask

   initial begin : stimulus
      logic [15:0] seq[$];
      logic [31:0] delta_val;
      logic [3:0]  bad;
      int          choice;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Straight after reset the directory length is zero, so
      // the very first word is answered as finished with no fixup needed;
      // with a delta loaded the same situation reports a normal finish.
      put_word(16'h0000);
      settle();
      configure(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      put_word(16'hFFFF);
      settle();

      // A full block at the top of the address space with every entry type,
      // a HIGHADJ inside the block and one whose low part lies past the
      // block end; then an empty block of size zero and one of odd size.
      // Walked bytes: 26 + 8 + 10 = 44, after which one stray word finishes.
      seq = '{16'hFFFF, 16'hFFFF, 16'h0018, 16'h0000,
              {perel_pkg::RT_ABSOLUTE, 12'hFFF}, {perel_pkg::RT_HIGH, 12'hFFF},
              {perel_pkg::RT_LOW, 12'h000}, {perel_pkg::RT_HIGHLOW, 12'hABC},
              {perel_pkg::RT_DIR64, 12'h123}, {perel_pkg::RT_HIGHADJ, 12'hFFF},
              16'hFFFF, {perel_pkg::RT_HIGHADJ, 12'h800}, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h1000, 16'h0000, 16'h0009, 16'h0000, {perel_pkg::RT_HIGHLOW, 12'h000},
              16'h5A5A};
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd44);
      foreach (seq[i]) begin
         put_word(seq[i]);
      end
      dir_cursor = 32'd44;
      settle();

      // Random part: mostly well-formed directories with random content,
      // a share of stray words past the end and of garbage entries under a
      // zero delta. The idling pattern swaps after a third of the words and
      // stops after two thirds.
      while (words_sent < WORD_TARGET) begin
         if (words_sent >= 2 * WORD_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (words_sent >= WORD_TARGET / 3) begin
            send_idle_pct = 53;
            recv_idle_pct = 25;
         end
         case ($urandom_range(9))
            0, 1:    delta_val = 32'h0000_0000;
            2:       delta_val = 32'hFFFF_FFFF;
            3:       delta_val = 32'h0000_0001;
            4:       delta_val = 32'h0001_0000;
            default: delta_val = $urandom;
         endcase
         choice = $urandom_range(19);
         if (choice == 0) begin
            run_phase(delta_val, pick_word32(), 0, 8, 1'b0, 1'b0);
         end else if (choice == 1) begin
            run_phase(delta_val, pick_word32(), $urandom_range(5, 2), 0, 1'b0, 1'b1);
         end else begin
            run_phase(delta_val, pick_word32(), $urandom_range(6, 1), $urandom_range(2),
                      $urandom_range(3) == 0, 1'b0);
         end
      end

      // The unknown type goes last, since the error never clears. The block
      // size word has its upper half set; two good entries, the offending
      // one, then words that all repeat the error.
      bad = perel_pkg::RT_ABSOLUTE;
      while (bad <= perel_pkg::RT_HIGHADJ || bad == perel_pkg::RT_DIR64) begin
         bad = 4'($urandom_range(15));
      end
      send_idle_pct = 25;
      recv_idle_pct = 53;
      configure($urandom | 32'h1, pick_word32(), dir_cursor + 32'd64);
      seq = '{16'h2000, 16'h0010, 16'h0018, 16'h0001,
              {perel_pkg::RT_HIGHLOW, 12'h010}, {perel_pkg::RT_LOW, 12'hFFE},
              {bad, 12'h7FF}};
      foreach (seq[i]) begin
         put_word(seq[i]);
      end
      repeat (5) put_word(16'($urandom));
      settle();

      $display("Covered %0d directory words over %0d register settings, %0d result beats.",
               words_sent, settings_used, beats_taken);
      $display("Headers, all entry kinds, HIGHADJ pairing, directory end and sticky error.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
